[hw/rtl/cmmke_pkg.sv]
// Package for the class-masked minimum key extraction block.
// Holds field widths, command codes, the sequencer state type and the class decoder.
// Depends on nothing.
package cmmke_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_W       = 30;
    localparam int CLASS_W     = 2;
    localparam int MASK_W      = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Class 0 and 1 map to their own bit, every other code to class 2.
    function automatic logic [MASK_W-1:0] class_bit(input logic [CLASS_W-1:0] code);
        logic [MASK_W-1:0] m;
        unique case (code)
            2'd0:    m = 3'b001;
            2'd1:    m = 3'b010;
            default: m = 3'b100;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/class_masked_min_key_extract.sv]
// Class-masked minimum key extraction: keyed table, each entry in up to three classes.
// Single module with key and class-mask memories scanned by one compare unit.
// Depends on cmmke_pkg.
//
//  channel | dir | beat contents
//  s_      | in  | tuser = cmd; tdata = entry_key, first_class, second_class, query_class
//  m_      | out | tuser = found; tdata = min_key (query beats only)
//
// Every item scans the whole table through one read port, one slot a cycle;
// no new item is taken until its scan and finish are done.
// After reset the class-mask memory is cleared, one slot a cycle, and s_tready
// stays low until every slot is cleared. A result waits in the output register while the
// next item is taken; a query finish holds until that register is free.
module class_masked_min_key_extract #(
    parameter int TABLE_DEPTH = cmmke_pkg::TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] cmd
    input  logic [39:0] s_tdata,   // [29:0] entry_key, [31:30] first_class,
                                   // [33:32] second_class, [35:34] query_class, [39:36] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // [0] found
    output logic [31:0] m_tdata    // [29:0] min_key, [31:30] zero
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int KEY_W  = cmmke_pkg::KEY_W;
    localparam int MASK_W = cmmke_pkg::MASK_W;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);

    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [MASK_W-1:0] mask_mem [TABLE_DEPTH];

    cmmke_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0] addr_reg;
    logic              issue_reg;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] idx_d_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [MASK_W-1:0] mask_rd_reg;

    logic              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [MASK_W-1:0] new_mask_reg;
    logic [MASK_W-1:0] want_reg;

    logic              found_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic [KEY_W-1:0]  best_key_reg;
    logic [MASK_W-1:0] old_mask_reg;
    logic              free_reg;
    logic [ADDR_W-1:0] free_slot_reg;

    logic              m_tvalid_reg;
    logic              m_found_reg;
    logic [KEY_W-1:0]  m_key_reg;

    logic              accept;
    logic              scan_done;
    logic              out_free;
    logic              wr_key_en;
    logic              wr_mask_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [MASK_W-1:0] wr_mask;
    logic              out_load;

    // Shared compare unit.
    logic key_eq;
    logic key_lt;
    assign key_eq = (key_rd_reg == key_reg);
    assign key_lt = (key_rd_reg < best_key_reg);

    assign accept    = s_tvalid && s_tready;
    assign scan_done = rd_vld_reg && (idx_d_reg == LAST_SLOT);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cmmke_pkg::ST_CLEAR: begin
                if (addr_reg == LAST_SLOT) state_next = cmmke_pkg::ST_IDLE;
            end
            cmmke_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = cmmke_pkg::ST_SCAN;
            end
            cmmke_pkg::ST_SCAN: begin
                if (scan_done) state_next = cmmke_pkg::ST_FINISH;
            end
            cmmke_pkg::ST_FINISH: begin
                if (cmd_reg == cmmke_pkg::CMD_LOAD || out_free) state_next = cmmke_pkg::ST_IDLE;
            end
            default: state_next = cmmke_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory write port and handshake.
    always_comb begin
        s_tready   = 1'b0;
        wr_key_en  = 1'b0;
        wr_mask_en = 1'b0;
        wr_addr    = addr_reg;
        wr_mask    = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            cmmke_pkg::ST_CLEAR: begin
                wr_mask_en = 1'b1;
            end
            cmmke_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            cmmke_pkg::ST_SCAN: begin
            end
            cmmke_pkg::ST_FINISH: begin
                // Writes here are idempotent, so a held finish may repeat them.
                if (cmd_reg == cmmke_pkg::CMD_LOAD) begin
                    if (found_reg) begin
                        wr_mask_en = 1'b1;
                        wr_addr    = slot_reg;
                        wr_mask    = old_mask_reg | new_mask_reg;
                    end else if (free_reg) begin
                        wr_key_en  = 1'b1;
                        wr_mask_en = 1'b1;
                        wr_addr    = free_slot_reg;
                        wr_mask    = new_mask_reg;
                    end
                end else begin
                    wr_mask_en = found_reg;
                    wr_addr    = slot_reg;
                    out_load   = out_free;
                end
            end
            default: begin
            end
        endcase
    end

    // Memories: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (wr_key_en) key_mem[wr_addr] <= key_reg;
        if (wr_mask_en) mask_mem[wr_addr] <= wr_mask;
        key_rd_reg  <= key_mem[addr_reg];
        mask_rd_reg <= mask_mem[addr_reg];
        idx_d_reg   <= addr_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cmmke_pkg::ST_CLEAR;
            addr_reg     <= '0;
            issue_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == cmmke_pkg::ST_SCAN) && issue_reg;
            unique case (state_reg)
                cmmke_pkg::ST_CLEAR: addr_reg <= addr_reg + 1'b1;
                cmmke_pkg::ST_IDLE: begin
                    addr_reg  <= '0;
                    issue_reg <= accept;
                end
                cmmke_pkg::ST_SCAN: begin
                    if (issue_reg) begin
                        addr_reg <= addr_reg + 1'b1;
                        if (addr_reg == LAST_SLOT) issue_reg <= 1'b0;
                    end
                end
                cmmke_pkg::ST_FINISH: addr_reg <= '0;
                default: addr_reg <= '0;
            endcase
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // Item capture and scan results.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_tuser;
            key_reg      <= s_tdata[29:0];
            new_mask_reg <= cmmke_pkg::class_bit(s_tdata[31:30])
                          | cmmke_pkg::class_bit(s_tdata[33:32]);
            want_reg     <= cmmke_pkg::class_bit(s_tdata[35:34]);
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end else if (state_reg == cmmke_pkg::ST_SCAN && rd_vld_reg) begin
            if (cmd_reg == cmmke_pkg::CMD_LOAD) begin
                if (mask_rd_reg != '0) begin
                    if (key_eq && !found_reg) begin
                        found_reg    <= 1'b1;
                        slot_reg     <= idx_d_reg;
                        old_mask_reg <= mask_rd_reg;
                    end
                end else if (!free_reg) begin
                    free_reg      <= 1'b1;
                    free_slot_reg <= idx_d_reg;
                end
            end else if ((mask_rd_reg & want_reg) != '0) begin
                if (!found_reg || key_lt) begin
                    found_reg    <= 1'b1;
                    slot_reg     <= idx_d_reg;
                    best_key_reg <= key_rd_reg;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg <= found_reg;
            m_key_reg   <= found_reg ? best_key_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {2'b00, m_key_reg};

endmodule

[test/class_masked_min_key_extract_tb.sv]
// Self-checking testbench for class_masked_min_key_extract: drives load and query beats and
// checks every extracted minimum against a table predictor or the expected value of a directed row.
// Depends on cmmke_pkg and the class_masked_min_key_extract RTL.
module class_masked_min_key_extract_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = cmmke_pkg::TABLE_DEPTH;
    localparam int KEY_W       = cmmke_pkg::KEY_W;
    localparam int CLASS_W     = cmmke_pkg::CLASS_W;
    localparam int MASK_W      = cmmke_pkg::MASK_W;

    localparam logic [CLASS_W-1:0] CLS0 = 2'd0;
    localparam logic [CLASS_W-1:0] CLS1 = 2'd1;
    localparam logic [CLASS_W-1:0] CLS2 = 2'd2;
    localparam logic [CLASS_W-1:0] CLS3 = 2'd3;   // aliases class 2
    localparam logic [KEY_W-1:0]   KEY_MAX = {KEY_W{1'b1}};
    localparam int ITEMS_PER_PHASE = 188;
    localparam int MIX_CHUNK       = 60;
    localparam int LONG_HOLD       = 700;
    localparam int PEND_DEPTH      = 1024;
    localparam int PLAN_ROWS       = 32;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [CLASS_W-1:0] c1;
        logic [CLASS_W-1:0] c2;
        logic [CLASS_W-1:0] qc;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key;
    } min_t;

    typedef struct {
        item_t item;
        bit    typed;
        min_t  want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        m_tuser;
    logic [31:0] m_tdata;

    logic [KEY_W-1:0]  tbl_key  [TABLE_DEPTH];
    logic [MASK_W-1:0] tbl_mask [TABLE_DEPTH];
    min_t              pending_mins [PEND_DEPTH];
    row_t              plan [PLAN_ROWS];

    int  pend_wr = 0;
    int  pend_rd = 0;
    int  plan_len = 0;
    int  err_count = 0;
    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;

    class_masked_min_key_extract dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
        err_count++;
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp);
    endtask

    function automatic logic [MASK_W-1:0] class_onehot(input logic [CLASS_W-1:0] code);
        return (code == CLS0) ? 3'b001 : (code == CLS1) ? 3'b010 : 3'b100;
    endfunction

    // Update the table for one accepted beat; return 1 when the beat yields a result.
    function automatic bit advance_table(input item_t it, output min_t res);
        logic [MASK_W-1:0] m;
        int free_slot;
        int best_slot;
        bit hit;
        res = '0;
        if (it.cmd == cmmke_pkg::CMD_LOAD) begin
            m = class_onehot(it.c1) | class_onehot(it.c2);
            free_slot = -1;
            hit = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (tbl_mask[i] != '0) begin
                    if (!hit && tbl_key[i] == it.key) begin
                        tbl_mask[i] = tbl_mask[i] | m;
                        hit = 1'b1;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            // drop a new key when every slot is live
            if (!hit && free_slot >= 0) begin
                tbl_key[free_slot] = it.key;
                tbl_mask[free_slot] = m;
            end
            return 1'b0;
        end
        m = class_onehot(it.qc);
        best_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if ((tbl_mask[i] & m) != '0) begin
                if (best_slot < 0 || tbl_key[i] < tbl_key[best_slot])
                    best_slot = i;
            end
        end
        if (best_slot >= 0) begin
            res.found = 1'b1;
            res.key = tbl_key[best_slot];
            tbl_mask[best_slot] = '0;
        end
        return 1'b1;
    endfunction

    function automatic void plan_row(input logic cmd, input logic [KEY_W-1:0] key,
                                     input logic [CLASS_W-1:0] c1,
                                     input logic [CLASS_W-1:0] c2,
                                     input logic [CLASS_W-1:0] qc,
                                     input bit typed, input logic found,
                                     input logic [KEY_W-1:0] min_key);
        row_t r;
        r.item = '{cmd: cmd, key: key, c1: c1, c2: c2, qc: qc};
        r.typed = typed;
        r.want = '{found: found, key: min_key};
        plan[plan_len] = r;
        plan_len++;
    endfunction

    function automatic item_t random_item(input int load_pct);
        item_t it;
        int pick;
        it.cmd = ($urandom_range(99) < load_pct) ? cmmke_pkg::CMD_LOAD : cmmke_pkg::CMD_QUERY;
        pick = $urandom_range(9);
        // favor a narrow key pool so duplicate loads hit live entries
        if (pick < 4)
            it.key = KEY_W'($urandom_range(255));
        else if (pick < 7)
            it.key = KEY_W'($urandom);
        else if (pick == 7)
            it.key = '0;
        else if (pick == 8)
            it.key = KEY_MAX;
        else
            it.key = KEY_MAX - KEY_W'($urandom_range(15));
        it.c1 = CLASS_W'($urandom_range(3));
        it.c2 = CLASS_W'($urandom_range(3));
        it.qc = CLASS_W'($urandom_range(3));
        return it;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input min_t want);
        int gap;
        min_t res;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {4'b0, it.qc, it.c2, it.c1, it.key};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (advance_table(it, res)) begin
            pending_mins[pend_wr % PEND_DEPTH] = typed ? want : res;
            pend_wr++;
        end
    endtask

    // Result side: check each beat, then pick m_tready for the next cycle.
    always @(posedge aclk) begin
        min_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            if (pend_wr == pend_rd) begin
                note_mismatch("unexpected result beat", m_tdata, 32'd0);
            end else begin
                exp = pending_mins[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (m_tuser !== exp.found)
                    note_mismatch("found", {31'd0, m_tuser}, {31'd0, exp.found});
                if (m_tdata[KEY_W-1:0] !== exp.key)
                    note_mismatch("min_key", m_tdata, {2'd0, exp.key});
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        int src_pct  [4];
        int sink_pct [4];
        int load_mix [4];
        int load_pct;

        src_pct  = '{0, 71, 0, 25};
        sink_pct = '{0, 0, 71, 25};
        load_mix = '{85, 85, 50, 25};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_key[i] = '0;
            tbl_mask[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, extremes, class 3 aliasing, duplicate keys, freed slots
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS0, 1, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, KEY_MAX, CLS3, CLS3, CLS3, 1, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, KEY_MAX, CLS0, CLS0, CLS3, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, '0, CLS1, CLS2, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'd5, CLS3, CLS3, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'd5, CLS0, CLS1, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS0, 1, 1'b1, 30'd5);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS1, 1, 1'b1, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS2, 1, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS0, 1, 1'b1, KEY_MAX);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS1, 1, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'h2AAAAAAA, CLS2, CLS0, CLS3, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'h15555555, CLS1, CLS3, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'h15555555, CLS1, CLS1, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS3, 1, 1'b1, 30'h15555555);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS0, 1, 1'b1, 30'h2AAAAAAA);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS2, 1, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'd7, CLS0, CLS1, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'd3, CLS1, CLS0, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'd9, CLS2, CLS2, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS1, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_LOAD, 30'd3, CLS2, CLS2, CLS0, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS2, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS1, 0, 1'b0, '0);
        plan_row(cmmke_pkg::CMD_QUERY, '0, CLS0, CLS0, CLS0, 0, 1'b0, '0);
        for (int i = 0; i < plan_len; i++)
            send_item(plan[i].item, plan[i].typed, plan[i].want);

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct = src_pct[phase];
            sink_stall_pct = sink_pct[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                load_pct = load_mix[(n / MIX_CHUNK) % 4];
                // hold the receiver off and keep offering queries until the input stalls
                if (phase == 0 && n == MIX_CHUNK)
                    hold_req = 1'b1;
                if (phase == 0 && n >= MIX_CHUNK && n < MIX_CHUNK + 24)
                    load_pct = 10;
                send_item(random_item(load_pct), 0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pend_wr != pend_rd)
            @(posedge aclk);
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
